/* sv/clm_pkg.sv */
// ----------------------------------------------------------------------------
// Circular list manager package
// Sizes, request codes and the structs passed between the list manager blocks.
// ----------------------------------------------------------------------------
package clm_pkg;

    localparam int NODE_COUNT = 64;
    localparam int RING_COUNT = 16;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int RING_W     = $clog2(RING_COUNT);
    localparam int TYPE_W     = 3;

    localparam int IN_BITS     = TYPE_W + 2 * RING_W + NODE_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = NODE_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [RING_W-1:0] ring_idx_t;
    typedef logic [TYPE_W-1:0] req_kind_t;

    localparam req_kind_t REQ_NEXT   = 3'd0;
    localparam req_kind_t REQ_REMOVE = 3'd1;
    localparam req_kind_t REQ_INSERT = 3'd2;
    localparam req_kind_t REQ_APPEND = 3'd3;
    localparam req_kind_t REQ_MOVE   = 3'd4;

    typedef struct packed {
        logic  we;
        node_t addr;
        node_t data;
    } link_wr_t;

    typedef struct packed {
        logic  we;
        node_t head;
        logic  nonempty;
    } ring_wr_t;

    typedef struct packed {
        node_t next_node;
        logic  has_next;
    } result_t;

endpackage

/* sv/clm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/clm_ring_table.sv */
// ----------------------------------------------------------------------------
// Ring table
// Head node and occupancy flag of every ring, read and written at one index.
// ----------------------------------------------------------------------------
module clm_ring_table
    import clm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ring_idx_t sel,
    input  ring_wr_t  wr,
    output node_t     head,
    output logic      nonempty
);

    node_t                 head_reg [RING_COUNT];
    logic [RING_COUNT-1:0] nonempty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '{default: '0};
            nonempty_reg <= '0;
        end else if (wr.we) begin
            head_reg[sel]     <= wr.head;
            nonempty_reg[sel] <= wr.nonempty;
        end
    end

    assign head     = head_reg[sel];
    assign nonempty = nonempty_reg[sel];

endmodule

/* sv/clm_seq.sv */
// ----------------------------------------------------------------------------
// List manager sequencer
// Steps one request through the reads and writes of the link memories.
// ----------------------------------------------------------------------------
module clm_seq
    import clm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  req_kind_t req_kind,
    input  ring_idx_t req_ring,
    input  ring_idx_t req_to_ring,
    input  node_t     req_node,
    input  logic      out_free,
    output logic      done,
    output result_t   res,
    output node_t     rd_addr,
    input  node_t     nxt_rdata,
    input  node_t     prv_rdata,
    output link_wr_t  nxt_wr,
    output link_wr_t  prv_wr,
    output ring_idx_t ring_sel,
    input  node_t     ring_head,
    input  logic      ring_nonempty,
    output ring_wr_t  ring_wr
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_NXT  = 7'b0000010,
        S_UNL  = 7'b0000100,
        S_LNK  = 7'b0001000,
        S_LKR  = 7'b0010000,
        S_LKW  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t    state_reg, state_next;
    req_kind_t kind_reg, kind_next;
    ring_idx_t cur_ring_reg, cur_ring_next;
    ring_idx_t to_ring_reg, to_ring_next;
    node_t     node_reg, node_next;
    node_t     tail_reg, tail_next;
    result_t   res_reg, res_next;
    logic      in_range;
    logic      to_in_range;

    assign in_range    = (32'(req_node) < NODE_COUNT) && (32'(req_ring) < RING_COUNT);
    assign to_in_range = 32'(req_to_ring) < RING_COUNT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        kind_reg     <= kind_next;
        cur_ring_reg <= cur_ring_next;
        to_ring_reg  <= to_ring_next;
        node_reg     <= node_next;
        tail_reg     <= tail_next;
        res_reg      <= res_next;
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cur_ring_next = cur_ring_reg;
        to_ring_next  = to_ring_reg;
        node_next     = node_reg;
        tail_next     = tail_reg;
        res_next      = res_reg;
        s_ready       = 1'b0;
        done          = 1'b0;
        rd_addr       = node_reg;
        nxt_wr        = '0;
        prv_wr        = '0;
        ring_wr       = '0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                rd_addr       = req_node;
                kind_next     = req_kind;
                cur_ring_next = req_ring;
                to_ring_next  = req_to_ring;
                node_next     = req_node;
                res_next      = '0;
                if (s_valid) begin
                    if (!in_range) begin
                        state_next = S_DONE;
                    end else begin
                        unique case (req_kind)
                            REQ_NEXT:   state_next = S_NXT;
                            REQ_REMOVE: state_next = S_UNL;
                            REQ_INSERT: state_next = S_LNK;
                            REQ_APPEND: state_next = S_LNK;
                            REQ_MOVE:   state_next = to_in_range ? S_UNL : S_DONE;
                            default:    state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_NXT: begin
                if (!(ring_nonempty && ring_head == nxt_rdata)) begin
                    res_next.next_node = nxt_rdata;
                    res_next.has_next  = 1'b1;
                end
                state_next = S_DONE;
            end
            S_UNL: begin
                nxt_wr = '{we: 1'b1, addr: prv_rdata, data: nxt_rdata};
                prv_wr = '{we: 1'b1, addr: nxt_rdata, data: prv_rdata};
                if (ring_nonempty && ring_head == node_reg) begin
                    ring_wr.we = 1'b1;
                    if (nxt_rdata == node_reg) begin
                        ring_wr.head     = '0;
                        ring_wr.nonempty = 1'b0;
                    end else begin
                        ring_wr.head     = nxt_rdata;
                        ring_wr.nonempty = 1'b1;
                    end
                end
                if (kind_reg == REQ_MOVE) begin
                    cur_ring_next = to_ring_reg;
                    state_next    = S_LNK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LNK: begin
                rd_addr = ring_head;
                if (!ring_nonempty) begin
                    nxt_wr  = '{we: 1'b1, addr: node_reg, data: node_reg};
                    prv_wr  = '{we: 1'b1, addr: node_reg, data: node_reg};
                    ring_wr = '{we: 1'b1, head: node_reg, nonempty: 1'b1};
                    state_next = S_DONE;
                end else begin
                    state_next = S_LKR;
                end
            end
            S_LKR: begin
                nxt_wr     = '{we: 1'b1, addr: node_reg, data: ring_head};
                prv_wr     = '{we: 1'b1, addr: node_reg, data: prv_rdata};
                tail_next  = prv_rdata;
                state_next = S_LKW;
            end
            S_LKW: begin
                nxt_wr = '{we: 1'b1, addr: tail_reg, data: node_reg};
                prv_wr = '{we: 1'b1, addr: ring_head, data: node_reg};
                if (kind_reg == REQ_INSERT) begin
                    ring_wr = '{we: 1'b1, head: node_reg, nonempty: 1'b1};
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res      = res_reg;
    assign ring_sel = cur_ring_reg;

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!nxt_wr.we && !prv_wr.we && !ring_wr.we))
        else $error("link or ring write while idle");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start");

    a_done_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> out_free)
        else $error("result issued into a full output register");

    a_empty_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_wr.we && !ring_wr.nonempty) |-> (ring_wr.head == '0))
        else $error("emptied ring keeps a head");

    a_result_only_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && res.has_next) |-> (kind_reg == REQ_NEXT))
        else $error("successor reported for a request other than next");

endmodule

/* sv/circular_list_manager.sv */
// ----------------------------------------------------------------------------
// Circular list manager
// Keeps several circular doubly linked rings over one table of nodes.
// ----------------------------------------------------------------------------
// A request item on the s_ channel names a request kind, a ring, a target ring
// for a move, and a node. Every request gives exactly one result item on the
// m_ channel: the successor of the node and a has_next flag for a next
// request, and zeros for all other kinds.
// The block works on one request at a time and drops s_tready while it does.
// A request steps through its own sequence of states: next and remove read the
// links of the node, a link into an occupied ring also reads the links of the
// ring head, and a move unlinks the node and then links it into the target ring.
// The sequence is set by the dependent reads of the two link memories, which
// return registered read data. A new request is accepted only after the previous
// one has handed its result to the output register.
// The result sits in an output register; a new request is accepted while it
// waits, but that request is not finished until the receiver takes the result.
// Reset empties all rings and clears their heads; the link memories are not
// cleared and hold nothing useful until nodes are linked.
// ----------------------------------------------------------------------------
module circular_list_manager
    import clm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // req_type, ring_id, to_ring_id, node_index, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // next_node, has_next, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    req_kind_t req_kind;
    ring_idx_t req_ring;
    ring_idx_t req_to_ring;
    node_t     req_node;
    logic      out_free;
    logic      done;
    result_t   res;
    node_t     rd_addr;
    node_t     nxt_rdata;
    node_t     prv_rdata;
    link_wr_t  nxt_wr;
    link_wr_t  prv_wr;
    ring_idx_t ring_sel;
    node_t     ring_head;
    logic      ring_nonempty;
    ring_wr_t  ring_wr;
    logic      m_tvalid_reg, m_tvalid_next;
    result_t   m_res_reg, m_res_next;

    assign req_kind    = s_tdata[TYPE_W-1:0];
    assign req_ring    = s_tdata[TYPE_W +: RING_W];
    assign req_to_ring = s_tdata[TYPE_W+RING_W +: RING_W];
    assign req_node    = s_tdata[TYPE_W+2*RING_W +: NODE_W];

    clm_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .req_kind      (req_kind),
        .req_ring      (req_ring),
        .req_to_ring   (req_to_ring),
        .req_node      (req_node),
        .out_free      (out_free),
        .done          (done),
        .res           (res),
        .rd_addr       (rd_addr),
        .nxt_rdata     (nxt_rdata),
        .prv_rdata     (prv_rdata),
        .nxt_wr        (nxt_wr),
        .prv_wr        (prv_wr),
        .ring_sel      (ring_sel),
        .ring_head     (ring_head),
        .ring_nonempty (ring_nonempty),
        .ring_wr       (ring_wr)
    );

    clm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_next_mem (
        .aclk  (aclk),
        .we    (nxt_wr.we),
        .waddr (nxt_wr.addr),
        .wdata (nxt_wr.data),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    clm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_prev_mem (
        .aclk  (aclk),
        .we    (prv_wr.we),
        .waddr (prv_wr.addr),
        .wdata (prv_wr.data),
        .raddr (rd_addr),
        .rdata (prv_rdata)
    );

    clm_ring_table u_ring_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sel      (ring_sel),
        .wr       (ring_wr),
        .head     (ring_head),
        .nonempty (ring_nonempty)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (done) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({m_res_reg.has_next, m_res_reg.next_node});

endmodule

/* test/tb_circular_list_manager.sv */
// ----------------------------------------------------------------------------
// Circular list manager testbench
// Sends next, remove, insert, append and move requests, plus reserved request
// kinds, and checks every result against a local copy of the ring state. A
// short scripted opening is followed by random requests. Most random requests
// keep the rings well formed. A final stretch mixes in requests for nodes that
// are not on the named ring. Both sides idle at random, and once the result
// side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_circular_list_manager;
    import clm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam req_kind_t REQ_RSVD5 = 3'd5;
    localparam req_kind_t REQ_RSVD6 = 3'd6;
    localparam req_kind_t REQ_RSVD7 = 3'd7;
    localparam int KIND_LAST    = (1 << TYPE_W) - 1;
    localparam int RANDOM_ITEMS = 930;
    localparam int ROUGH_ITEMS  = 70;
    localparam int IDLE_PCT     = 12;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int SCRIPT_LEN   = 24;

    typedef struct packed {
        req_kind_t kind;
        ring_idx_t ring;
        ring_idx_t dest;
        node_t     node;
        logic      fixed;
        node_t     want_node;
        logic      want_next;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{REQ_RSVD5,  4'd0,  4'd0,  6'd0,  1'b1, 6'd0,  1'b0},
        '{REQ_INSERT, 4'd0,  4'd0,  6'd0,  1'b1, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd0,  4'd0,  6'd0,  1'b1, 6'd0,  1'b0},
        '{REQ_APPEND, 4'd0,  4'd0,  6'd63, 1'b1, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd0,  4'd0,  6'd0,  1'b1, 6'd63, 1'b1},
        '{REQ_NEXT,   4'd0,  4'd0,  6'd63, 1'b1, 6'd0,  1'b0},
        '{REQ_INSERT, 4'd15, 4'd0,  6'd42, 1'b1, 6'd0,  1'b0},
        '{REQ_APPEND, 4'd15, 4'd0,  6'd21, 1'b1, 6'd0,  1'b0},
        '{REQ_INSERT, 4'd15, 4'd0,  6'd7,  1'b1, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd15, 4'd0,  6'd7,  1'b1, 6'd42, 1'b1},
        '{REQ_REMOVE, 4'd15, 4'd0,  6'd42, 1'b0, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd15, 4'd0,  6'd7,  1'b1, 6'd21, 1'b1},
        '{REQ_MOVE,   4'd15, 4'd15, 6'd7,  1'b0, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd15, 4'd0,  6'd21, 1'b1, 6'd7,  1'b1},
        '{REQ_MOVE,   4'd0,  4'd15, 6'd63, 1'b0, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd15, 4'd0,  6'd7,  1'b1, 6'd63, 1'b1},
        '{REQ_REMOVE, 4'd0,  4'd0,  6'd0,  1'b0, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd0,  4'd0,  6'd0,  1'b1, 6'd0,  1'b1},
        '{REQ_RSVD6,  4'd15, 4'd0,  6'd21, 1'b1, 6'd0,  1'b0},
        '{REQ_RSVD7,  4'd10, 4'd5,  6'd63, 1'b1, 6'd0,  1'b0},
        '{REQ_REMOVE, 4'd15, 4'd0,  6'd21, 1'b0, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd15, 4'd0,  6'd63, 1'b1, 6'd0,  1'b0},
        '{REQ_MOVE,   4'd15, 4'd0,  6'd63, 1'b0, 6'd0,  1'b0},
        '{REQ_NEXT,   4'd0,  4'd0,  6'd63, 1'b1, 6'd0,  1'b0}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    node_t     succ_of     [NODE_COUNT];
    node_t     pred_of     [NODE_COUNT];
    bit        linked_once [NODE_COUNT];
    node_t     head_of     [RING_COUNT];
    bit        ring_live   [RING_COUNT];
    result_t   pending_replies [$];

    int  errors;
    int  sent;
    int  compared;
    int  kind_seen [KIND_LAST+1];
    bit  no_idle;

    circular_list_manager dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10) begin
            $display("tb: mismatch: %s", msg);
        end
    endfunction

    function automatic void unlink_from(ring_idx_t r, node_t n);
        node_t nx;
        node_t pv;
        nx = succ_of[n];
        pv = pred_of[n];
        succ_of[pv] = nx;
        pred_of[nx] = pv;
        if (ring_live[r] && head_of[r] == n) begin
            if (nx == n) begin
                ring_live[r] = 1'b0;
                head_of[r]   = '0;
            end else begin
                head_of[r] = nx;
            end
        end
    endfunction

    function automatic void link_at_tail(ring_idx_t r, node_t n);
        node_t h;
        node_t tl;
        if (!ring_live[r]) begin
            succ_of[n]   = n;
            pred_of[n]   = n;
            head_of[r]   = n;
            ring_live[r] = 1'b1;
        end else begin
            h  = head_of[r];
            tl = pred_of[h];
            succ_of[n]  = h;
            pred_of[n]  = tl;
            succ_of[tl] = n;
            pred_of[h]  = n;
        end
        linked_once[n] = 1'b1;
    endfunction

    function automatic result_t apply_list_request(req_kind_t k, ring_idx_t r, ring_idx_t t,
                                                   node_t n);
        result_t res;
        res = '0;
        case (k)
            REQ_NEXT: begin
                if (!(ring_live[r] && head_of[r] == succ_of[n])) begin
                    res.next_node = succ_of[n];
                    res.has_next  = 1'b1;
                end
            end
            REQ_REMOVE: unlink_from(r, n);
            REQ_INSERT: begin
                link_at_tail(r, n);
                head_of[r] = n;
            end
            REQ_APPEND: link_at_tail(r, n);
            REQ_MOVE: begin
                unlink_from(r, n);
                link_at_tail(t, n);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic node_t any_linked_node();
        int pool [$];
        for (int i = 0; i < NODE_COUNT; i++) begin
            if (linked_once[i]) begin
                pool.push_back(i);
            end
        end
        return node_t'(pool[$urandom_range(0, pool.size() - 1)]);
    endfunction

    task automatic pick_request(input bit rough, output req_kind_t k, output ring_idx_t r,
                                output ring_idx_t t, output node_t n);
        int owner [NODE_COUNT];
        int pool [$];
        int roll;
        int p;
        k = REQ_NEXT;
        r = ring_idx_t'($urandom_range(0, RING_COUNT - 1));
        t = ring_idx_t'($urandom_range(0, RING_COUNT - 1));
        n = node_t'($urandom_range(0, NODE_COUNT - 1));
        if (rough) begin
            k = req_kind_t'($urandom_range(0, KIND_LAST));
            if (k != REQ_INSERT && k != REQ_APPEND) begin
                n = any_linked_node();
            end
            return;
        end
        if ($urandom_range(0, 1)) begin
            r = ring_idx_t'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 1)) begin
            t = ring_idx_t'($urandom_range(0, 3));
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            k = req_kind_t'($urandom_range(REQ_MOVE + 1, KIND_LAST));
            n = any_linked_node();
            return;
        end
        if (roll < 12) begin
            n = any_linked_node();
            return;
        end
        foreach (owner[i]) begin
            owner[i] = -1;
        end
        for (int rr = 0; rr < RING_COUNT; rr++) begin
            if (ring_live[rr]) begin
                p = head_of[rr];
                for (int s = 0; s < NODE_COUNT; s++) begin
                    owner[p] = rr;
                    p = succ_of[p];
                    if (p == head_of[rr]) begin
                        break;
                    end
                end
            end
        end
        foreach (owner[i]) begin
            if (owner[i] < 0) begin
                pool.push_back(i);
            end
        end
        if (pool.size() == NODE_COUNT || (roll < 40 && pool.size() > 0)) begin
            k = $urandom_range(0, 1) ? REQ_INSERT : REQ_APPEND;
            n = node_t'(pool[$urandom_range(0, pool.size() - 1)]);
            return;
        end
        pool.delete();
        for (int rr = 0; rr < RING_COUNT; rr++) begin
            if (ring_live[rr]) begin
                pool.push_back(rr);
            end
        end
        r = ring_idx_t'(pool[$urandom_range(0, pool.size() - 1)]);
        pool.delete();
        foreach (owner[i]) begin
            if (owner[i] == r) begin
                pool.push_back(i);
            end
        end
        n = node_t'(pool[$urandom_range(0, pool.size() - 1)]);
        if (roll < 65) begin
            k = REQ_NEXT;
        end else if (roll < 85) begin
            k = REQ_REMOVE;
        end else begin
            k = REQ_MOVE;
        end
    endtask

    task automatic send_request(req_kind_t k, ring_idx_t r, ring_idx_t t, node_t n);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({n, t, r, k});
        do @(posedge aclk); while (!s_tready);
        sent++;
        kind_seen[k]++;
    endtask

    initial begin
        req_kind_t k;
        ring_idx_t r;
        ring_idx_t t;
        node_t     n;
        result_t   want;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        no_idle  = 1'b0;
        foreach (ring_live[i]) begin
            ring_live[i] = 1'b0;
            head_of[i]   = '0;
        end
        foreach (linked_once[i]) begin
            linked_once[i] = 1'b0;
            succ_of[i]     = '0;
            pred_of[i]     = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (SCRIPT[i]) begin
            send_request(SCRIPT[i].kind, SCRIPT[i].ring, SCRIPT[i].dest, SCRIPT[i].node);
            want = apply_list_request(SCRIPT[i].kind, SCRIPT[i].ring, SCRIPT[i].dest,
                                      SCRIPT[i].node);
            if (SCRIPT[i].fixed) begin
                want.next_node = SCRIPT[i].want_node;
                want.has_next  = SCRIPT[i].want_next;
            end
            pending_replies.push_back(want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 300 && i < 450);
            pick_request(i >= RANDOM_ITEMS - ROUGH_ITEMS, k, r, t, n);
            send_request(k, r, t, n);
            pending_replies.push_back(apply_list_request(k, r, t, n));
        end
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("tb: %0d requests (%0d scripted), %0d results compared, one %0d-cycle hold-off",
                 sent, SCRIPT_LEN, compared, HOLD_CYCLES);
        $display("tb: next %0d, remove %0d, insert %0d, append %0d, move %0d, reserved %0d",
                 kind_seen[REQ_NEXT], kind_seen[REQ_REMOVE], kind_seen[REQ_INSERT],
                 kind_seen[REQ_APPEND], kind_seen[REQ_MOVE],
                 kind_seen[REQ_RSVD5] + kind_seen[REQ_RSVD6] + kind_seen[REQ_RSVD7]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        forever begin
            if (!held && sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        node_t   got_node;
        logic    got_next;
        got_node = m_tdata[NODE_W-1:0];
        got_next = m_tdata[NODE_W];
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                note_error($sformatf("result node=%0d has_next=%0b with no request waiting",
                                     got_node, got_next));
            end else begin
                want = pending_replies.pop_front();
                compared++;
                if (got_node !== want.next_node) begin
                    note_error($sformatf("result %0d next_node expected %0d got %0d",
                                         compared, want.next_node, got_node));
                end
                if (got_next !== want.has_next) begin
                    note_error($sformatf("result %0d has_next expected %0b got %0b",
                                         compared, want.has_next, got_next));
                end
            end
        end
    end

endmodule
